[sv/drmt_pkg.sv]
`timescale 1ns / 1ps
// Shared constants and codes for the damage rectangle merge tracker.
// No dependencies; compile first.
package drmt_pkg;

   localparam int MAX_RECTS_DEF    = 32;
   localparam int COORD_BITS_DEF   = 12;
   localparam int FUNC_W           = 2;
   localparam int STATUS_W         = 4;
   localparam int LIMIT_W          = 25;
   localparam int CSR_INDEX_W      = 3;
   localparam int CSR_DATA_W       = 25;
   localparam logic [LIMIT_W-1:0] AREA_LIMIT_RESET = 25'd4096;

   typedef enum logic [FUNC_W-1:0] {
      FUNC_INSERT = 2'd0,
      FUNC_INVAL  = 2'd1,
      FUNC_DRAIN  = 2'd2,
      FUNC_RSVD   = 2'd3
   } func_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_EMPTY     = 4'd0,
      ST_CONTAINED = 4'd1,
      ST_MERGED    = 4'd2,
      ST_APPENDED  = 4'd3,
      ST_OVERFLOW  = 4'd4,
      ST_WAS_FULL  = 4'd5,
      ST_ALL_SET   = 4'd6,
      ST_RECT_OUT  = 4'd7,
      ST_FULL      = 4'd8,
      ST_NOTHING   = 4'd9
   } status_type;

   localparam logic [CSR_INDEX_W-1:0] CSR_CLIENT_WIDTH  = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_CLIENT_HEIGHT = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_BD_ENABLE     = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_BD_LEFT       = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_BD_TOP        = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] CSR_BD_RIGHT      = 3'd5;
   localparam logic [CSR_INDEX_W-1:0] CSR_BD_BOTTOM     = 3'd6;
   localparam logic [CSR_INDEX_W-1:0] CSR_AREA_LIMIT    = 3'd7;

endpackage

[sv/drmt_ifs.sv]
`timescale 1ns / 1ps
// Valid/ready channel interfaces for request and response items.
// Depends on drmt_pkg.
interface drmt_req_if #(parameter int COORD_BITS = drmt_pkg::COORD_BITS_DEF);
   import drmt_pkg::*;
   logic                  valid;
   logic                  ready;
   logic [FUNC_W-1:0]     func;
   logic [COORD_BITS-1:0] rect_left;
   logic [COORD_BITS-1:0] rect_top;
   logic [COORD_BITS-1:0] rect_right;
   logic [COORD_BITS-1:0] rect_bottom;
   modport source (output valid, func, rect_left, rect_top, rect_right, rect_bottom,
                   input ready);
   modport sink   (input valid, func, rect_left, rect_top, rect_right, rect_bottom,
                   output ready);
endinterface

interface drmt_rsp_if #(parameter int COORD_BITS = drmt_pkg::COORD_BITS_DEF);
   import drmt_pkg::*;
   logic                  valid;
   logic                  ready;
   logic [STATUS_W-1:0]   status;
   logic [COORD_BITS-1:0] out_left;
   logic [COORD_BITS-1:0] out_top;
   logic [COORD_BITS-1:0] out_right;
   logic [COORD_BITS-1:0] out_bottom;
   logic                  last;
   modport source (output valid, status, out_left, out_top, out_right, out_bottom, last,
                   input ready);
   modport sink   (input valid, status, out_left, out_top, out_right, out_bottom, last,
                   output ready);
endinterface

[sv/drmt_rect_mem.sv]
`timescale 1ns / 1ps
// Rectangle table storage: one write port, one read port with registered data.
// Depends on nothing but its parameters.
module drmt_rect_mem #(
   parameter int DEPTH  = 32,
   parameter int ADDR_W = 5,
   parameter int DATA_W = 48
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [DATA_W-1:0] wr_data,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [DATA_W-1:0] rd_data
);

   logic [DATA_W-1:0] mem_ff [DEPTH];
   logic [DATA_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

[sv/damage_rect_merge_tracker.sv]
`timescale 1ns / 1ps
// Damage rectangle merge tracker, top level.
// Depends on drmt_pkg, drmt_ifs (drmt_req_if, drmt_rsp_if) and drmt_rect_mem.
//
// Usage: a request item on req_ch carries func (insert, invalidate all, drain)
// and, for insert, a rectangle. Every request gives one or more response items
// on rsp_ch; the last one of a request has last set. Insert and invalidate give
// exactly one; a drain gives either one full-frame or nothing item, or one
// item per stored rectangle that meets the client area.
// Configuration goes through csr_write/csr_index/csr_wdata, one register per
// cycle; the user must write only while idle, which the block does not enforce.
// Flow: one request is worked at a time; req_ch.ready is high only when the
// sequencer is idle. An insert reads up to N stored entries, one table read per
// cycle, for the containment scan, then again for the merge scan, and tests the
// union area of each overlapping entry on the single multiplier. The single
// table read port sets the scan rate.
// A finished response sits in an output register, so a new request may be
// taken while it waits. If rsp_ch stalls, the sequencer holds until the
// register frees up; nothing is dropped.
// Reset (synchronous, active high) empties the table count, clears full and
// pending flags and restores the configuration defaults; table contents stay.
module damage_rect_merge_tracker #(
   parameter int MAX_RECTS  = drmt_pkg::MAX_RECTS_DEF,
   parameter int COORD_BITS = drmt_pkg::COORD_BITS_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   drmt_req_if.sink                           req_ch,
   drmt_rsp_if.source                         rsp_ch,
   input  logic                               csr_write,
   input  logic [drmt_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [drmt_pkg::CSR_DATA_W-1:0]    csr_wdata
);
   import drmt_pkg::*;

   localparam int CNT_W  = $clog2(MAX_RECTS + 1);
   localparam int IDX_W  = (MAX_RECTS > 1) ? $clog2(MAX_RECTS) : 1;
   localparam int AREA_W = 2 * COORD_BITS;
   localparam int CMP_W  = (AREA_W > LIMIT_W) ? AREA_W : LIMIT_W;
   localparam int BOX_L  = 0;
   localparam int BOX_T  = 1;
   localparam int BOX_R  = 2;
   localparam int BOX_B  = 3;

   typedef logic [3:0][COORD_BITS-1:0] box_type;

   typedef enum logic [9:0] {
      S_IDLE     = 10'b00_0000_0001,
      S_DECODE   = 10'b00_0000_0010,
      S_CHECK    = 10'b00_0000_0100,
      S_BACKDROP = 10'b00_0000_1000,
      S_HOLD     = 10'b00_0001_0000,
      S_MERGE    = 10'b00_0010_0000,
      S_MUL      = 10'b00_0100_0000,
      S_CMP      = 10'b00_1000_0000,
      S_DRAIN    = 10'b01_0000_0000,
      S_RESP     = 10'b10_0000_0000
   } state_type;

   // Shared rectangle arithmetic: min/max joins and edge compares.
   function automatic box_type box_and(box_type a, box_type b);
      box_type o;
      o[BOX_L] = (a[BOX_L] > b[BOX_L]) ? a[BOX_L] : b[BOX_L];
      o[BOX_T] = (a[BOX_T] > b[BOX_T]) ? a[BOX_T] : b[BOX_T];
      o[BOX_R] = (a[BOX_R] < b[BOX_R]) ? a[BOX_R] : b[BOX_R];
      o[BOX_B] = (a[BOX_B] < b[BOX_B]) ? a[BOX_B] : b[BOX_B];
      return o;
   endfunction

   function automatic box_type box_or(box_type a, box_type b);
      box_type o;
      o[BOX_L] = (a[BOX_L] < b[BOX_L]) ? a[BOX_L] : b[BOX_L];
      o[BOX_T] = (a[BOX_T] < b[BOX_T]) ? a[BOX_T] : b[BOX_T];
      o[BOX_R] = (a[BOX_R] > b[BOX_R]) ? a[BOX_R] : b[BOX_R];
      o[BOX_B] = (a[BOX_B] > b[BOX_B]) ? a[BOX_B] : b[BOX_B];
      return o;
   endfunction

   function automatic logic box_empty(box_type a);
      return (a[BOX_R] <= a[BOX_L]) || (a[BOX_B] <= a[BOX_T]);
   endfunction

   function automatic logic box_holds(box_type outer, box_type inner);
      return (outer[BOX_L] <= inner[BOX_L]) && (outer[BOX_T] <= inner[BOX_T]) &&
             (inner[BOX_R] <= outer[BOX_R]) && (inner[BOX_B] <= outer[BOX_B]);
   endfunction

   // Configuration registers
   logic [COORD_BITS-1:0] client_w_ff, client_h_ff;
   logic                  bd_en_ff;
   logic [COORD_BITS-1:0] bd_l_ff, bd_t_ff, bd_r_ff, bd_b_ff;
   logic [LIMIT_W-1:0]    limit_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         client_w_ff <= '0;
         client_h_ff <= '0;
         bd_en_ff    <= 1'b0;
         bd_l_ff     <= '0;
         bd_t_ff     <= '0;
         bd_r_ff     <= '0;
         bd_b_ff     <= '0;
         limit_ff    <= AREA_LIMIT_RESET;
      end else if (csr_write) begin
         case (csr_index)
            CSR_CLIENT_WIDTH:  client_w_ff <= csr_wdata[COORD_BITS-1:0];
            CSR_CLIENT_HEIGHT: client_h_ff <= csr_wdata[COORD_BITS-1:0];
            CSR_BD_ENABLE:     bd_en_ff    <= csr_wdata[0];
            CSR_BD_LEFT:       bd_l_ff     <= csr_wdata[COORD_BITS-1:0];
            CSR_BD_TOP:        bd_t_ff     <= csr_wdata[COORD_BITS-1:0];
            CSR_BD_RIGHT:      bd_r_ff     <= csr_wdata[COORD_BITS-1:0];
            CSR_BD_BOTTOM:     bd_b_ff     <= csr_wdata[COORD_BITS-1:0];
            CSR_AREA_LIMIT:    limit_ff    <= csr_wdata[LIMIT_W-1:0];
            default: ;
         endcase
      end
   end

   box_type client_box, bd_box;
   always_comb begin
      client_box[BOX_L] = '0;
      client_box[BOX_T] = '0;
      client_box[BOX_R] = client_w_ff;
      client_box[BOX_B] = client_h_ff;
      bd_box[BOX_L] = bd_l_ff;
      bd_box[BOX_T] = bd_t_ff;
      bd_box[BOX_R] = bd_r_ff;
      bd_box[BOX_B] = bd_b_ff;
   end

   // Sequencer and working registers
   state_type             state_ff, state_in;
   func_type              func_ff, func_in;
   box_type               box_ff, box_in;
   box_type               u_ff, u_in;
   box_type               pend_ff, pend_in;
   logic                  pend_valid_ff, pend_valid_in;
   logic [AREA_W-1:0]     area_ff, area_in;
   logic [CNT_W-1:0]      idx_ff, idx_in;
   logic [CNT_W-1:0]      count_ff, count_in;
   logic [CNT_W-1:0]      scan_n_ff, scan_n_in;
   logic                  full_ff, full_in;
   logic                  paint_ff, paint_in;
   status_type            res_ff, res_in;

   // Output register
   logic                  rsp_valid_ff, rsp_valid_in;
   status_type            rsp_status_ff, rsp_status_in;
   box_type               rsp_box_ff, rsp_box_in;
   logic                  rsp_last_ff, rsp_last_in;

   // Table port
   logic                  mem_wr_en;
   logic [IDX_W-1:0]      mem_wr_addr;
   box_type               mem_wr_data;
   box_type               entry;

   logic                  slot_free;
   logic                  rsp_load;
   logic                  req_take;
   logic [COORD_BITS-1:0] u_w, u_h;

   assign slot_free = !rsp_valid_ff || rsp_ch.ready;
   assign req_take  = req_ch.valid && (state_ff == S_IDLE);
   assign u_w = u_ff[BOX_R] - u_ff[BOX_L];
   assign u_h = u_ff[BOX_B] - u_ff[BOX_T];

   drmt_rect_mem #(
      .DEPTH  (MAX_RECTS),
      .ADDR_W (IDX_W),
      .DATA_W (4 * COORD_BITS)
   ) u_table (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data),
      .rd_addr (idx_in[IDX_W-1:0]),
      .rd_data (entry)
   );

   always_comb begin
      state_in      = state_ff;
      func_in       = func_ff;
      box_in        = box_ff;
      u_in          = u_ff;
      pend_in       = pend_ff;
      pend_valid_in = pend_valid_ff;
      area_in       = area_ff;
      idx_in        = idx_ff;
      count_in      = count_ff;
      scan_n_in     = scan_n_ff;
      full_in       = full_ff;
      paint_in      = paint_ff;
      res_in        = res_ff;
      mem_wr_en     = 1'b0;
      mem_wr_addr   = count_ff[IDX_W-1:0];
      mem_wr_data   = box_ff;
      rsp_load      = 1'b0;
      rsp_status_in = rsp_status_ff;
      rsp_box_in    = rsp_box_ff;
      rsp_last_in   = rsp_last_ff;

      case (state_ff)
         S_IDLE: begin
            if (req_ch.valid) begin
               func_in        = func_type'(req_ch.func);
               box_in[BOX_L]  = req_ch.rect_left;
               box_in[BOX_T]  = req_ch.rect_top;
               box_in[BOX_R]  = req_ch.rect_right;
               box_in[BOX_B]  = req_ch.rect_bottom;
               state_in       = S_DECODE;
            end
         end
         S_DECODE: begin
            pend_valid_in = 1'b0;
            idx_in        = '0;
            case (func_ff)
               FUNC_INSERT: begin
                  box_in   = box_and(box_ff, client_box);
                  state_in = S_CHECK;
               end
               FUNC_INVAL: begin
                  paint_in = 1'b1;
                  full_in  = 1'b1;
                  count_in = '0;
                  res_in   = ST_ALL_SET;
                  state_in = S_RESP;
               end
               FUNC_DRAIN: begin
                  if (paint_ff) begin
                     paint_in  = 1'b0;
                     full_in   = 1'b0;
                     count_in  = '0;
                     scan_n_in = count_ff;
                     if (full_ff) begin
                        res_in   = ST_FULL;
                        state_in = S_RESP;
                     end else begin
                        state_in = S_DRAIN;
                     end
                  end else begin
                     res_in   = ST_NOTHING;
                     state_in = S_RESP;
                  end
               end
               default: begin
                  res_in   = ST_NOTHING;
                  state_in = S_RESP;
               end
            endcase
         end
         S_CHECK: begin
            if (box_empty(box_ff)) begin
               res_in   = ST_EMPTY;
               state_in = S_RESP;
            end else begin
               state_in = S_BACKDROP;
            end
         end
         S_BACKDROP: begin
            // When the backdrop is enabled and meets the box, join with it, then clip again.
            if (bd_en_ff && !box_empty(box_and(bd_box, box_ff))) begin
               box_in = box_and(box_or(box_ff, bd_box), client_box);
            end
            paint_in = 1'b1;
            idx_in   = '0;
            if (full_ff) begin
               res_in   = ST_WAS_FULL;
               state_in = S_RESP;
            end else begin
               state_in = S_HOLD;
            end
         end
         S_HOLD: begin
            // Containment scan, one entry per cycle.
            if (idx_ff == count_ff) begin
               idx_in   = '0;
               state_in = S_MERGE;
            end else if (box_holds(entry, box_ff)) begin
               res_in   = ST_CONTAINED;
               state_in = S_RESP;
            end else begin
               idx_in = idx_ff + 1'b1;
            end
         end
         S_MERGE: begin
            if (idx_ff == count_ff) begin
               if (count_ff == CNT_W'(MAX_RECTS)) begin
                  full_in  = 1'b1;
                  count_in = '0;
                  res_in   = ST_OVERFLOW;
               end else begin
                  mem_wr_en = 1'b1;
                  count_in  = count_ff + 1'b1;
                  res_in    = ST_APPENDED;
               end
               state_in = S_RESP;
            end else if (!box_empty(box_and(entry, box_ff))) begin
               u_in     = box_or(entry, box_ff);
               state_in = S_MUL;
            end else begin
               idx_in = idx_ff + 1'b1;
            end
         end
         S_MUL: begin
            area_in  = AREA_W'(u_w) * AREA_W'(u_h);
            state_in = S_CMP;
         end
         S_CMP: begin
            if (CMP_W'(area_ff) <= CMP_W'(limit_ff)) begin
               mem_wr_en   = 1'b1;
               mem_wr_addr = idx_ff[IDX_W-1:0];
               mem_wr_data = u_ff;
               res_in      = ST_MERGED;
               state_in    = S_RESP;
            end else begin
               idx_in   = idx_ff + 1'b1;
               state_in = S_MERGE;
            end
         end
         S_DRAIN: begin
            // Keep one found rectangle back so the final one can carry last.
            if (idx_ff == scan_n_ff) begin
               res_in   = pend_valid_ff ? ST_RECT_OUT : ST_NOTHING;
               state_in = S_RESP;
            end else if (!box_empty(box_and(entry, client_box))) begin
               if (!pend_valid_ff) begin
                  pend_in       = entry;
                  pend_valid_in = 1'b1;
                  idx_in        = idx_ff + 1'b1;
               end else if (slot_free) begin
                  rsp_load      = 1'b1;
                  rsp_status_in = ST_RECT_OUT;
                  rsp_box_in    = pend_ff;
                  rsp_last_in   = 1'b0;
                  pend_in       = entry;
                  idx_in        = idx_ff + 1'b1;
               end
            end else begin
               idx_in = idx_ff + 1'b1;
            end
         end
         S_RESP: begin
            if (slot_free) begin
               rsp_load      = 1'b1;
               rsp_status_in = res_ff;
               rsp_box_in    = (res_ff == ST_RECT_OUT) ? pend_ff : '0;
               rsp_last_in   = 1'b1;
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ch.ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         count_ff      <= '0;
         full_ff       <= 1'b0;
         paint_ff      <= 1'b0;
         pend_valid_ff <= 1'b0;
         idx_ff        <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         count_ff      <= count_in;
         full_ff       <= full_in;
         paint_ff      <= paint_in;
         pend_valid_ff <= pend_valid_in;
         idx_ff        <= idx_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      func_ff       <= func_in;
      box_ff        <= box_in;
      u_ff          <= u_in;
      pend_ff       <= pend_in;
      area_ff       <= area_in;
      scan_n_ff     <= scan_n_in;
      res_ff        <= res_in;
      rsp_status_ff <= rsp_status_in;
      rsp_box_ff    <= rsp_box_in;
      rsp_last_ff   <= rsp_last_in;
   end

   assign req_ch.ready      = (state_ff == S_IDLE);
   assign rsp_ch.valid      = rsp_valid_ff;
   assign rsp_ch.status     = rsp_status_ff;
   assign rsp_ch.out_left   = rsp_box_ff[BOX_L];
   assign rsp_ch.out_top    = rsp_box_ff[BOX_T];
   assign rsp_ch.out_right  = rsp_box_ff[BOX_R];
   assign rsp_ch.out_bottom = rsp_box_ff[BOX_B];
   assign rsp_ch.last       = rsp_last_ff;

   // Table fill never passes its depth.
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(MAX_RECTS))
      else $error("rect count beyond table depth");

   // Full-frame mode always comes with an empty table.
   a_full_empty: assert property (@(posedge clock) disable iff (reset)
      full_ff |-> (count_ff == '0))
      else $error("full mode with stored rectangles");

   // A taken request always starts the decode step.
   a_take_decode: assert property (@(posedge clock) disable iff (reset)
      req_take |=> (state_ff == S_DECODE))
      else $error("request taken without decode");

   // A rectangle result that is not last leaves one more in hand.
   a_drain_more: assert property (@(posedge clock) disable iff (reset)
      (rsp_load && !rsp_last_in) |=> pend_valid_ff)
      else $error("non-final drain item without a pending rectangle");

endmodule
